/* hw/rtl/pbc_pkg.sv */
package pbc_pkg;

    localparam int unsigned SYM_W     = 8;
    localparam int unsigned SKIP_W    = 16;
    localparam int unsigned OUT_CNT_W = 16;
    localparam int unsigned NUM_CNT   = 5;

    localparam logic [SKIP_W-1:0] SKIP_MAX = '1;

    // Characters of the pileup base string
    localparam logic [SYM_W-1:0] SYM_A_UP   = 8'h41;
    localparam logic [SYM_W-1:0] SYM_A_LO   = 8'h61;
    localparam logic [SYM_W-1:0] SYM_C_UP   = 8'h43;
    localparam logic [SYM_W-1:0] SYM_C_LO   = 8'h63;
    localparam logic [SYM_W-1:0] SYM_G_UP   = 8'h47;
    localparam logic [SYM_W-1:0] SYM_G_LO   = 8'h67;
    localparam logic [SYM_W-1:0] SYM_T_UP   = 8'h54;
    localparam logic [SYM_W-1:0] SYM_T_LO   = 8'h74;
    localparam logic [SYM_W-1:0] SYM_STAR   = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_N_UP   = 8'h4E;
    localparam logic [SYM_W-1:0] SYM_CARET  = 8'h5E;
    localparam logic [SYM_W-1:0] SYM_DOLLAR = 8'h24;
    localparam logic [SYM_W-1:0] SYM_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_ZERO   = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE   = 8'h39;

    // Count slots
    localparam int unsigned IDX_A   = 0;
    localparam int unsigned IDX_C   = 1;
    localparam int unsigned IDX_G   = 2;
    localparam int unsigned IDX_T   = 3;
    localparam int unsigned IDX_GAP = 4;

    typedef enum logic [3:0] {
        CLS_A,
        CLS_C,
        CLS_G,
        CLS_T,
        CLS_GAP,
        CLS_CARET,
        CLS_DOLLAR,
        CLS_INDEL,
        CLS_DIGIT,
        CLS_OTHER
    } t_sym_class;

    typedef struct packed {
        t_sym_class cls;
        logic [3:0] digit;
    } t_sym_info;

endpackage

/* hw/rtl/pileup_base_counter.sv */
// Path: the input register takes the last character of a position, and the result register
//   then loads the position's result from it; a held result transaction can stall this.
// Throughput: one character per cycle; the per-character state update is a single
//   register-to-register pass, so the only stall is a held result transaction.
// Reset: i_rst_n is synchronous, active low; it empties both stages and clears
//   all counts, the indel length, and the quality-skip and error flags.
module pileup_base_counter
    import pbc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: one character per transaction
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,   // last_symbol
    // Master side: one result per position
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // [15:0] count_a, [31:16] count_c,
                                        // [47:32] count_g, [63:48] count_t,
                                        // [79:64] count_gap, [80] bad_symbol,
                                        // [87:81] zero
);

    // Input register stage
    logic             r_s1_valid;
    logic [SYM_W-1:0] r_s1_symbol;
    logic             r_s1_last;

    // Result register stage
    logic             r_out_valid;
    logic [87:0]      r_out_data;

    logic      out_free;
    logic      s1_go;
    t_sym_info sym_info;

    logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] cnt_final;
    logic [NUM_CNT-1:0][OUT_CNT_W-1:0]   cnt_out;
    logic                                bad_final;

    // The result register can take a new result when empty or draining now
    assign out_free = !r_out_valid || m_axis_tready;
    // A non-last character never needs the result register, so it always advances
    assign s1_go    = r_s1_valid && (!r_s1_last || out_free);
    assign s_axis_tready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_symbol <= s_axis_tdata;
            r_s1_last   <= s_axis_tlast;
        end
    end

    pbc_decode u_decode (
        .i_symbol (r_s1_symbol),
        .o_info   (sym_info)
    );

    pbc_state #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (s1_go),
        .i_last   (r_s1_last),
        .i_info   (sym_info),
        .o_counts (cnt_final),
        .o_bad    (bad_final)
    );

    // Fit each count to the 16-bit output field: keep the low bits or zero-extend
    genvar k;
    generate
        for (k = 0; k < NUM_CNT; k++) begin : g_cnt
            if (COUNT_WIDTH >= OUT_CNT_W) begin : g_trunc
                assign cnt_out[k] = cnt_final[k][OUT_CNT_W-1:0];
            end else begin : g_ext
                assign cnt_out[k] = {{(OUT_CNT_W-COUNT_WIDTH){1'b0}}, cnt_final[k]};
            end
        end
    endgenerate

    // Load a result on the last character; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out_data <= {7'b0000000, bad_final, cnt_out[IDX_GAP], cnt_out[IDX_T],
                           cnt_out[IDX_G], cnt_out[IDX_C], cnt_out[IDX_A]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* hw/rtl/pbc_decode.sv */
module pbc_decode
    import pbc_pkg::*;
(
    input  logic [SYM_W-1:0] i_symbol,
    output t_sym_info        o_info
);

    logic [SYM_W-1:0] digit_full;

    assign digit_full = i_symbol - SYM_ZERO;

    always_comb begin
        o_info.digit = digit_full[3:0];
        case (i_symbol)
            SYM_A_UP, SYM_A_LO:   o_info.cls = CLS_A;
            SYM_C_UP, SYM_C_LO:   o_info.cls = CLS_C;
            SYM_G_UP, SYM_G_LO:   o_info.cls = CLS_G;
            SYM_T_UP, SYM_T_LO:   o_info.cls = CLS_T;
            SYM_STAR, SYM_N_UP:   o_info.cls = CLS_GAP;
            SYM_CARET:            o_info.cls = CLS_CARET;
            SYM_DOLLAR:           o_info.cls = CLS_DOLLAR;
            SYM_PLUS, SYM_MINUS:  o_info.cls = CLS_INDEL;
            default: begin
                if (i_symbol inside {[SYM_ZERO:SYM_NINE]}) begin
                    o_info.cls = CLS_DIGIT;
                end else begin
                    o_info.cls = CLS_OTHER;
                end
            end
        endcase
    end

endmodule

/* hw/rtl/pbc_state.sv */
module pbc_state
    import pbc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_go,
    input  logic                                i_last,
    input  t_sym_info                           i_info,
    output logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] o_counts,
    output logic                                o_bad
);

    logic                                r_skip_q,  n_skip_q;
    logic                                r_reading, n_reading;
    logic [SKIP_W-1:0]                   r_skip,    n_skip;
    logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] r_counts,  n_counts;
    logic                                r_err,     n_err;

    logic [SKIP_W+3:0] len_acc;
    logic [SKIP_W-1:0] skip_dec;

    // len * 10 + digit, wide enough to see overflow
    assign len_acc  = {1'b0, r_skip, 3'b000} + {3'b000, r_skip, 1'b0}
                    + {{SKIP_W{1'b0}}, i_info.digit};
    assign skip_dec = (r_skip != '0) ? r_skip - 1'b1 : r_skip;

    always_comb begin
        n_skip_q  = r_skip_q;
        n_reading = r_reading;
        n_skip    = r_skip;
        n_counts  = r_counts;
        n_err     = r_err;
        if (r_skip_q) begin
            n_skip_q = 1'b0;
        end else if (i_info.cls == CLS_INDEL) begin
            n_reading = 1'b1;
            n_skip    = '0;
        end else if (r_reading) begin
            if (i_info.cls == CLS_DIGIT) begin
                n_skip = (len_acc > {4'b0000, SKIP_MAX}) ? SKIP_MAX : len_acc[SKIP_W-1:0];
            end else begin
                // terminating character is the first skipped base
                n_reading = 1'b0;
                n_skip    = skip_dec;
            end
        end else if (r_skip != '0) begin
            n_skip = skip_dec;
        end else begin
            case (i_info.cls)
                CLS_A: begin
                    if (r_counts[IDX_A] != '1) n_counts[IDX_A] = r_counts[IDX_A] + 1'b1;
                end
                CLS_C: begin
                    if (r_counts[IDX_C] != '1) n_counts[IDX_C] = r_counts[IDX_C] + 1'b1;
                end
                CLS_G: begin
                    if (r_counts[IDX_G] != '1) n_counts[IDX_G] = r_counts[IDX_G] + 1'b1;
                end
                CLS_T: begin
                    if (r_counts[IDX_T] != '1) n_counts[IDX_T] = r_counts[IDX_T] + 1'b1;
                end
                CLS_GAP: begin
                    if (r_counts[IDX_GAP] != '1) n_counts[IDX_GAP] = r_counts[IDX_GAP] + 1'b1;
                end
                CLS_CARET:  n_skip_q = 1'b1;
                CLS_DOLLAR: ;
                default:    n_err = 1'b1;
            endcase
        end
    end

    // Final values of the position leave with the last character
    assign o_counts = n_counts;
    assign o_bad    = n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_q  <= 1'b0;
            r_reading <= 1'b0;
            r_skip    <= '0;
            r_counts  <= '0;
            r_err     <= 1'b0;
        end else if (i_go) begin
            if (i_last) begin
                r_skip_q  <= 1'b0;
                r_reading <= 1'b0;
                r_skip    <= '0;
                r_counts  <= '0;
                r_err     <= 1'b0;
            end else begin
                r_skip_q  <= n_skip_q;
                r_reading <= n_reading;
                r_skip    <= n_skip;
                r_counts  <= n_counts;
                r_err     <= n_err;
            end
        end
    end

endmodule

/* dv/tb_pileup_base_counter.sv */
`timescale 1ns / 100ps

module tb_pileup_base_counter;
    import pbc_pkg::*;

    localparam int CNT_W       = 16;
    localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;
    localparam int RANDOM_CHARS = 410;
    localparam int TAIL_CHARS  = 60;      // no idling once this few remain
    localparam int HOLD_AT     = 150;     // start the long result hold-off here
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int WD_LIMIT    = 1000;

    // Bytes outside the pileup alphabet, at the ends of the symbol range
    localparam logic [SYM_W-1:0] SYM_NUL  = 8'h00;
    localparam logic [SYM_W-1:0] SYM_HIGH = 8'hFF;

    localparam logic [SYM_W-1:0] BASE_SET [10] = '{
        SYM_A_UP, SYM_A_LO, SYM_C_UP, SYM_C_LO, SYM_G_UP,
        SYM_G_LO, SYM_T_UP, SYM_T_LO, SYM_N_UP, SYM_STAR
    };

    typedef struct {
        logic [SYM_W-1:0] sym;
        logic             last;
    } t_char_xact;

    // Same layout as m_axis_tdata, highest field first
    typedef struct packed {
        logic [6:0]           pad;
        logic                 bad_symbol;
        logic [OUT_CNT_W-1:0] count_gap;
        logic [OUT_CNT_W-1:0] count_t;
        logic [OUT_CNT_W-1:0] count_g;
        logic [OUT_CNT_W-1:0] count_c;
        logic [OUT_CNT_W-1:0] count_a;
    } t_base_tally;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] symbol
    logic        s_axis_tlast = 1'b0;   // last_symbol
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;          // [15:0] count_a, [31:16] count_c, [47:32] count_g,
                                        // [63:48] count_t, [79:64] count_gap, [80] bad_symbol

    pileup_base_counter #(
        .COUNT_WIDTH(CNT_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction state: mirrors the counter's own state
    // ------------------------------------------------------------------
    logic              qual_skip;
    logic              in_length;
    int unsigned       skip_left;
    longint unsigned   tally [NUM_CNT];
    logic              saw_bad;

    t_char_xact  char_q [$];
    t_base_tally pending_counts [$];
    logic [SYM_W-1:0] pos_q [$];

    int chars_total;
    int chars_in;
    int results_out;
    int mismatches;

    task automatic clear_tally();
        qual_skip = 1'b0;
        in_length = 1'b0;
        skip_left = 0;
        saw_bad   = 1'b0;
        foreach (tally[k]) tally[k] = 0;
    endtask

    task automatic bump_tally(input int k);
        if (tally[k] < CNT_MAX) tally[k]++;
    endtask

    // Advance the predicted state by one accepted character; on the marked
    // last character, queue the expected result and clear.
    task automatic count_symbol(input logic [SYM_W-1:0] sym, input logic last);
        int unsigned dig;
        t_base_tally res;
        if (qual_skip) begin
            qual_skip = 1'b0;
        end else if (sym == SYM_PLUS || sym == SYM_MINUS) begin
            in_length = 1'b1;
            skip_left = 0;
        end else if (in_length) begin
            if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
                dig = sym - SYM_ZERO;
                if (skip_left > (int'(SKIP_MAX) - dig) / 10) skip_left = SKIP_MAX;
                else skip_left = skip_left * 10 + dig;
            end else begin
                // The terminating character is the first skipped base
                in_length = 1'b0;
                if (skip_left > 0) skip_left--;
            end
        end else if (skip_left > 0) begin
            skip_left--;
        end else begin
            case (sym)
                SYM_A_UP, SYM_A_LO: bump_tally(IDX_A);
                SYM_C_UP, SYM_C_LO: bump_tally(IDX_C);
                SYM_G_UP, SYM_G_LO: bump_tally(IDX_G);
                SYM_T_UP, SYM_T_LO: bump_tally(IDX_T);
                SYM_STAR, SYM_N_UP: bump_tally(IDX_GAP);
                SYM_CARET:          qual_skip = 1'b1;
                SYM_DOLLAR:         ;
                default:            saw_bad = 1'b1;
            endcase
        end
        if (last) begin
            res = '0;
            res.count_a    = tally[IDX_A][OUT_CNT_W-1:0];
            res.count_c    = tally[IDX_C][OUT_CNT_W-1:0];
            res.count_g    = tally[IDX_G][OUT_CNT_W-1:0];
            res.count_t    = tally[IDX_T][OUT_CNT_W-1:0];
            res.count_gap  = tally[IDX_GAP][OUT_CNT_W-1:0];
            res.bad_symbol = saw_bad;
            pending_counts = {pending_counts, res};
            clear_tally();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic flush_position();
        t_char_xact x;
        foreach (pos_q[k]) begin
            x.sym  = pos_q[k];
            x.last = (k == pos_q.size() - 1);
            char_q = {char_q, x};
        end
        pos_q.delete();
    endtask

    function automatic logic [SYM_W-1:0] rand_base();
        return BASE_SET[$urandom_range(0, 9)];
    endfunction

    // Mostly well-formed base strings with random content; some noise and
    // some strings cut off mid-token (after a caret, inside an indel).
    task automatic add_random_position();
        int n_tok;
        int pick;
        int len;
        int cut;
        string digits;
        pos_q.delete();
        if ($urandom_range(0, 99) < 15) begin
            n_tok = $urandom_range(1, 10);
            repeat (n_tok) pos_q = {pos_q, 8'($urandom_range(0, 255))};
        end else begin
            n_tok = $urandom_range(1, 12);
            repeat (n_tok) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    pos_q = {pos_q, rand_base()};
                end else if (pick < 65) begin
                    pos_q = {pos_q, SYM_DOLLAR};
                end else if (pick < 77) begin
                    pos_q = {pos_q, SYM_CARET};
                    pos_q = {pos_q, 8'($urandom_range(0, 255))};
                end else if (pick < 95) begin
                    pos_q = {pos_q, ($urandom_range(0, 1) ? SYM_PLUS : SYM_MINUS)};
                    len = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 99999)
                                                       : $urandom_range(0, 6);
                    if ($urandom_range(0, 9) != 0) begin
                        digits = $sformatf("%0d", len);
                        for (int k = 0; k < digits.len(); k++) pos_q = {pos_q, digits[k]};
                    end
                    repeat ((len <= 8) ? len : $urandom_range(0, 8)) pos_q = {pos_q, rand_base()};
                end else begin
                    pos_q = {pos_q, 8'($urandom_range(0, 255))};
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, pos_q.size());
                while (pos_q.size() > cut) void'(pos_q.pop_back());
            end
        end
        flush_position();
    endtask

    // ------------------------------------------------------------------
    // Driver: offer characters from char_q, with random idle bursts
    // ------------------------------------------------------------------
    int         gap_left;
    logic       offer;
    t_char_xact nxt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            gap_left = 0;
            clear_tally();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                count_symbol(s_axis_tdata, s_axis_tlast);
                chars_in++;
            end
            // Hold an offered transaction until it is taken
            if (!s_axis_tvalid || s_axis_tready) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (char_q.size() > TAIL_CHARS && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 11);
                end else if (char_q.size() > 0) begin
                    nxt   = char_q.pop_front();
                    offer = 1'b1;
                end
                s_axis_tvalid <= offer;
                if (offer) begin
                    s_axis_tdata <= nxt.sym;
                    s_axis_tlast <= nxt.last;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random result stalls, one long hold-off, compare results
    // ------------------------------------------------------------------
    int          stall_left;
    int          hold_left;
    logic        hold_done = 1'b0;
    logic        rdy;
    t_base_tally got;
    t_base_tally want;

    task automatic check_field(input string name, input logic [OUT_CNT_W-1:0] exp_v,
                               input logic [OUT_CNT_W-1:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_out++;
                got = t_base_tally'(m_axis_tdata);
                if (pending_counts.size() == 0) begin
                    $error("result transaction with no expected result waiting");
                    mismatches++;
                end else begin
                    want = pending_counts.pop_front();
                    check_field("count_a",    want.count_a,    got.count_a);
                    check_field("count_c",    want.count_c,    got.count_c);
                    check_field("count_g",    want.count_g,    got.count_g);
                    check_field("count_t",    want.count_t,    got.count_t);
                    check_field("count_gap",  want.count_gap,  got.count_gap);
                    check_field("bad_symbol", want.bad_symbol, got.bad_symbol);
                end
            end
            // Hold off long enough for both stages to fill and stall the input
            if (!hold_done && chars_in >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (char_q.size() > TAIL_CHARS && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 11);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_axis_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles with no transaction on either side
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build the stimulus, release reset, wait for the drain
    // ------------------------------------------------------------------
    int mark;

    initial begin
        chars_in    = 0;
        results_out = 0;
        mismatches  = 0;

        // Every base in both cases, both gap symbols, a dollar
        pos_q = '{SYM_A_LO, SYM_A_UP, SYM_C_LO, SYM_C_UP, SYM_G_LO, SYM_G_UP,
                  SYM_T_LO, SYM_T_UP, SYM_STAR, SYM_N_UP, SYM_DOLLAR};
        flush_position();
        // Quality byte that looks like an indel start is just skipped
        pos_q = '{SYM_CARET, SYM_PLUS, SYM_G_UP};
        flush_position();
        // Length 2: the terminator is the first skipped base, then one more
        pos_q = '{SYM_PLUS, SYM_ZERO + 8'd2, SYM_T_UP, SYM_G_UP, SYM_C_UP};
        flush_position();
        // Indel without digits, then unknown bytes at both ends of the range
        pos_q = '{SYM_MINUS, SYM_G_UP, SYM_NUL, SYM_HIGH};
        flush_position();
        // Length saturates, everything after is skipped
        pos_q = '{SYM_PLUS, SYM_NINE, SYM_NINE, SYM_NINE, SYM_NINE, SYM_NINE, SYM_A_UP};
        flush_position();

        mark = char_q.size() + RANDOM_CHARS;
        while (char_q.size() < mark) add_random_position();

        mark = char_q.size() + TAIL_CHARS;
        while (char_q.size() < mark) add_random_position();
        chars_total = char_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (chars_in < chars_total || pending_counts.size() != 0);
        // Catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_counts.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/pbc_pkg.sv
hw/rtl/pbc_decode.sv
hw/rtl/pbc_state.sv
hw/rtl/pileup_base_counter.sv
dv/tb_pileup_base_counter.sv
